@@ rtl/core/ofl_pkg.sv @@
// ----------------------------------------------------------------------------
// ofl_pkg
// Shared types and constants of the oscillator frequency lock.
// ----------------------------------------------------------------------------
package ofl_pkg;

  localparam int RING_DEPTH = 3;
  localparam int DAC_BITS   = 12;
  localparam int SLOT_W     = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  localparam int COUNT_W    = 32;
  localparam int STEP_W     = 12;
  localparam int HOLD_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;
  localparam int SUM_W      = ((DAC_BITS > STEP_W) ? DAC_BITS : STEP_W) + 1;

  localparam logic [DAC_BITS-1:0]   LEVEL_MAX   = {DAC_BITS{1'b1}};
  localparam logic [DAC_BITS-1:0]   LEVEL_RESET = DAC_BITS'(2050);

  localparam logic [COUNT_W-1:0]    HIGH_LIMIT_RESET  = 32'd20000001;
  localparam logic [COUNT_W-1:0]    LOW_LIMIT_RESET   = 32'd19999999;
  localparam logic [STEP_W-1:0]     TUNE_STEP_RESET   = 12'd10;
  localparam logic [HOLD_W-1:0]     LED_HOLD_MS_RESET = 16'd100;

  localparam logic [CFG_IDX_W-1:0]  REG_HIGH_LIMIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0]  REG_LOW_LIMIT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0]  REG_TUNE_STEP   = 2'd2;
  localparam logic [CFG_IDX_W-1:0]  REG_LED_HOLD_MS = 2'd3;

  localparam logic signed [1:0] CORR_NONE = 2'sb00;
  localparam logic signed [1:0] CORR_UP   = 2'sb01;
  localparam logic signed [1:0] CORR_DOWN = 2'sb11;

  localparam logic FUNC_PULSE = 1'b0;
  localparam logic FUNC_TICK  = 1'b1;

  typedef struct packed {
    logic fire;
    logic pulse;
  } ofl_step_t;

endpackage

@@ rtl/core/ofl_ring.sv @@
// ----------------------------------------------------------------------------
// ofl_ring
// Sample ring with modulo slot counter, agreement check and published count.
// ----------------------------------------------------------------------------
module ofl_ring (
  input  logic                      clk,
  input  logic                      rst,
  input  ofl_pkg::ofl_step_t        step,
  input  logic [ofl_pkg::COUNT_W-1:0] count,
  output logic                      agree,
  output logic [ofl_pkg::COUNT_W-1:0] published_next
);
  import ofl_pkg::*;

  logic [COUNT_W-1:0]    ring [RING_DEPTH];
  logic [RING_DEPTH-1:0] slot_valid;
  logic [RING_DEPTH-1:0] slot_valid_next;
  logic [SLOT_W-1:0]     write_slot;
  logic [SLOT_W-1:0]     write_slot_next;
  logic [COUNT_W-1:0]    published;
  logic [COUNT_W-1:0]    view [RING_DEPTH];
  logic [RING_DEPTH-1:0] view_valid;
  logic [RING_DEPTH-1:0] match;

  always_comb begin
    for (int i = 0; i < RING_DEPTH; i++) begin
      view[i]       = (write_slot == SLOT_W'(i)) ? count : ring[i];
      view_valid[i] = slot_valid[i] | (write_slot == SLOT_W'(i));
    end
    for (int i = 0; i < RING_DEPTH; i++) begin
      match[i] = view_valid[i] && (view[i] == view[0]);
    end
    agree = step.fire && step.pulse && (&match);
    published_next = agree ? view[0] : published;
    slot_valid_next = view_valid & ~(agree ? RING_DEPTH'(1) : '0);
    write_slot_next = (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0 : write_slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (step.fire && step.pulse) begin
      ring[write_slot] <= count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      write_slot <= '0;
      published  <= '0;
    end else if (step.fire && step.pulse) begin
      slot_valid <= slot_valid_next;
      write_slot <= write_slot_next;
      published  <= published_next;
    end
  end

  a_slot_in_range: assert property (@(posedge clk) disable iff (rst)
    write_slot <= SLOT_W'(RING_DEPTH - 1))
    else $error("slot counter out of range");

  a_agree_clears_slot0: assert property (@(posedge clk) disable iff (rst)
    agree |=> !slot_valid[0])
    else $error("slot 0 still valid after agreement");

endmodule

@@ rtl/core/ofl_tune.sv @@
// ----------------------------------------------------------------------------
// ofl_tune
// DAC tuning level with saturating step up or down on agreement.
// ----------------------------------------------------------------------------
module ofl_tune (
  input  logic                         clk,
  input  logic                         rst,
  input  ofl_pkg::ofl_step_t           step,
  input  logic                         agree,
  input  logic [ofl_pkg::COUNT_W-1:0]  count,
  input  logic [ofl_pkg::COUNT_W-1:0]  high_limit,
  input  logic [ofl_pkg::COUNT_W-1:0]  low_limit,
  input  logic [ofl_pkg::STEP_W-1:0]   tune_step,
  output logic [ofl_pkg::DAC_BITS-1:0] level_next,
  output logic signed [1:0]            corr
);
  import ofl_pkg::*;

  logic [DAC_BITS-1:0] level;
  logic [SUM_W-1:0]    level_ext;
  logic [SUM_W-1:0]    step_ext;
  logic [SUM_W-1:0]    up_sum;
  logic [DAC_BITS-1:0] down_val;
  logic [DAC_BITS-1:0] up_val;

  always_comb begin
    level_ext = SUM_W'(level);
    step_ext  = SUM_W'(tune_step);
    up_sum    = level_ext + step_ext;
    down_val  = (level_ext > step_ext) ? DAC_BITS'(level_ext - step_ext) : '0;
    up_val    = (up_sum > SUM_W'(LEVEL_MAX)) ? LEVEL_MAX : DAC_BITS'(up_sum);
    level_next = level;
    if (agree) begin
      if (count > high_limit) begin
        level_next = down_val;
      end else if (count < low_limit) begin
        level_next = up_val;
      end
    end
    if (level_next < level) begin
      corr = CORR_DOWN;
    end else if (level_next > level) begin
      corr = CORR_UP;
    end else begin
      corr = CORR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level <= LEVEL_RESET;
    end else if (step.fire) begin
      level <= level_next;
    end
  end

  a_level_moves_on_agree: assert property (@(posedge clk) disable iff (rst)
    !agree |=> $stable(level))
    else $error("tuning level moved without agreement");

endmodule

@@ rtl/core/ofl_led.sv @@
// ----------------------------------------------------------------------------
// ofl_led
// Millisecond timer and pulse indicator with hold time.
// ----------------------------------------------------------------------------
module ofl_led (
  input  logic                        clk,
  input  logic                        rst,
  input  ofl_pkg::ofl_step_t          step,
  input  logic [ofl_pkg::HOLD_W-1:0]  led_hold_ms,
  output logic                        led_next
);
  import ofl_pkg::*;

  logic [HOLD_W-1:0] ms_since_pulse;
  logic [HOLD_W-1:0] ms_since_pulse_next;
  logic              led;

  always_comb begin
    if (step.pulse) begin
      ms_since_pulse_next = '0;
      led_next            = 1'b1;
    end else begin
      ms_since_pulse_next = (&ms_since_pulse) ? ms_since_pulse : ms_since_pulse + 1'b1;
      led_next            = (ms_since_pulse_next > led_hold_ms) ? 1'b0 : led;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ms_since_pulse <= '0;
      led            <= 1'b0;
    end else if (step.fire) begin
      ms_since_pulse <= ms_since_pulse_next;
      led            <= led_next;
    end
  end

endmodule

@@ rtl/core/oscillator_frequency_lock_top.sv @@
// ----------------------------------------------------------------------------
// oscillator_frequency_lock_top
// Data path: a beat passes through the input register and then the result
// register. Throughput: one beat per cycle while out_ready does not stall the
// output, set by the single-pass update between the two registers.
// Reset clears all control state; limits, step and hold time return to their
// defaults and the tuning level returns to 2050.
// ----------------------------------------------------------------------------
module oscillator_frequency_lock_top (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ofl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [ofl_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            func,
  input  logic [ofl_pkg::COUNT_W-1:0]     pulse_count,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ofl_pkg::DAC_BITS-1:0]    tune_level,
  output logic                            indicator_on,
  output logic [ofl_pkg::COUNT_W-1:0]     agreed_count,
  output logic                            agreed_now,
  output logic signed [1:0]               correction
);
  import ofl_pkg::*;

  logic [COUNT_W-1:0]  high_limit;
  logic [COUNT_W-1:0]  low_limit;
  logic [STEP_W-1:0]   tune_step;
  logic [HOLD_W-1:0]   led_hold_ms;

  logic                buf_valid;
  logic                buf_func;
  logic [COUNT_W-1:0]  buf_count;
  logic                advance;
  ofl_step_t           step;

  logic                agree;
  logic [COUNT_W-1:0]  published_next;
  logic [DAC_BITS-1:0] level_next;
  logic signed [1:0]   corr;
  logic                led_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      high_limit  <= HIGH_LIMIT_RESET;
      low_limit   <= LOW_LIMIT_RESET;
      tune_step   <= TUNE_STEP_RESET;
      led_hold_ms <= LED_HOLD_MS_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_HIGH_LIMIT:  high_limit  <= cfg_data[COUNT_W-1:0];
        REG_LOW_LIMIT:   low_limit   <= cfg_data[COUNT_W-1:0];
        REG_TUNE_STEP:   tune_step   <= cfg_data[STEP_W-1:0];
        REG_LED_HOLD_MS: led_hold_ms <= cfg_data[HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign advance    = buf_valid && (!out_valid || out_ready);
  assign in_ready   = !buf_valid || advance;
  assign step.fire  = advance;
  assign step.pulse = (buf_func == FUNC_PULSE);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_valid <= 1'b0;
    end else if (in_ready) begin
      buf_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_func  <= func;
      buf_count <= pulse_count;
    end
  end

  ofl_ring u_ring (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .count          (buf_count),
    .agree          (agree),
    .published_next (published_next)
  );

  ofl_tune u_tune (
    .clk        (clk),
    .rst        (rst),
    .step       (step),
    .agree      (agree),
    .count      (published_next),
    .high_limit (high_limit),
    .low_limit  (low_limit),
    .tune_step  (tune_step),
    .level_next (level_next),
    .corr       (corr)
  );

  ofl_led u_led (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .led_hold_ms (led_hold_ms),
    .led_next    (led_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      tune_level   <= level_next;
      indicator_on <= led_next;
      agreed_count <= published_next;
      agreed_now   <= agree;
      correction   <= corr;
    end
  end

  a_corr_needs_agree: assert property (@(posedge clk) disable iff (rst)
    out_valid && (correction != CORR_NONE) |-> agreed_now)
    else $error("correction without agreement");

  a_agree_lights_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && agreed_now |-> indicator_on)
    else $error("agreement beat with indicator off");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> buf_valid && out_valid && !out_ready)
    else $error("input stalled while a stage is free");

endmodule
